// ===== design/mpq_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mpq_pkg: shared types and codes of the multilevel priority queue
// Operation codes, status codes and the fixed widths of the transaction fields.
// ----------------------------------------------------------------------------
package mpq_pkg;

  localparam int LEVEL_W  = 3;
  localparam int VALUE_W  = 32;

  typedef enum logic {
    OP_ENQ = 1'b0,
    OP_DEQ = 1'b1
  } op_t;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_OVERFLOW  = 2'd1,
    ST_UNDERFLOW = 2'd2
  } status_t;

endpackage

// ===== design/mpq_slot_ram.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mpq_slot_ram: slot storage of the queue levels
// Simple dual-port memory, one write and one registered read per cycle.
// ----------------------------------------------------------------------------
module mpq_slot_ram #(
  parameter int WORDS  = 64,
  parameter int ADDR_W = 6,
  parameter int DATA_W = 32
) (
  input  logic              clk,
  input  logic              wr_en,
  input  logic [ADDR_W-1:0] wr_addr,
  input  logic [DATA_W-1:0] wr_data,
  input  logic              rd_en,
  input  logic [ADDR_W-1:0] rd_addr,
  output logic [DATA_W-1:0] rd_data
);

  logic [DATA_W-1:0] slot_mem_r [WORDS];
  logic [DATA_W-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      slot_mem_r[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= slot_mem_r[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

// ===== design/multilevel_priority_queue.sv =====
// ----------------------------------------------------------------------------
// multilevel_priority_queue: one linear queue per priority level
// Dequeue scans the levels from level 0 to the first non-empty one and reads its head slot; underflow after all LEVELS.
// Throughput: one transaction at a time, in_ready returns as soon as the result is latched.
// Reset: synchronous, active low; every level empties and the slots are not cleared.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
module multilevel_priority_queue #(
  parameter int LEVELS     = 8,
  parameter int DEPTH      = 8,
  parameter int DATA_WIDTH = 32
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  mpq_pkg::op_t                   in_operation,
  input  logic [mpq_pkg::LEVEL_W-1:0]    in_level,
  input  logic signed [mpq_pkg::VALUE_W-1:0] in_value,
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic signed [mpq_pkg::VALUE_W-1:0] out_result_value,
  output mpq_pkg::status_t               out_status
);

  import mpq_pkg::*;

  // Derived sizes. Slot address is level * DEPTH + index, as a flat memory.
  localparam int LVL_W  = $clog2(LEVELS);
  localparam int IDX_W  = $clog2(DEPTH);
  localparam int WORDS  = LEVELS * DEPTH;
  localparam int ADDR_W = $clog2(WORDS);
  localparam logic [LVL_W-1:0] LAST_LVL = LVL_W'(LEVELS - 1);
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(DEPTH - 1);

  typedef enum logic [1:0] {
    S_IDLE,
    S_ENQ,
    S_SCAN,
    S_READ
  } state_t;

  state_t                     state_r;
  logic [LEVEL_W-1:0]         lvl_r;
  logic signed [VALUE_W-1:0]  val_r;
  logic [LVL_W-1:0]           scan_r;
  logic [IDX_W-1:0]           head_r [LEVELS];
  logic [IDX_W-1:0]           tail_r [LEVELS];
  logic [LEVELS-1:0]          busy_r;
  logic                       out_valid_r;
  logic signed [VALUE_W-1:0]  out_value_r;
  status_t                    out_status_r;

  logic                       out_free;
  logic                       out_load;
  logic                       lvl_ok;
  logic [LVL_W-1:0]           lvl_idx;
  logic                       enq_busy;
  logic [IDX_W-1:0]           enq_tail;
  logic                       enq_full;
  logic [IDX_W-1:0]           enq_slot;
  logic                       scan_hit;
  logic [IDX_W-1:0]           scan_head;
  logic [IDX_W-1:0]           scan_tail;
  logic                       ram_we;
  logic [ADDR_W-1:0]          ram_waddr;
  logic [DATA_WIDTH-1:0]      ram_wdata;
  logic                       ram_re;
  logic [ADDR_W-1:0]          ram_raddr;
  logic [DATA_WIDTH-1:0]      ram_rdata;

  function automatic logic [ADDR_W-1:0] slot_addr(input logic [LVL_W-1:0] lvl,
                                                  input logic [IDX_W-1:0] idx);
    int flat;
    flat = int'(lvl) * DEPTH + int'(idx);
    return ADDR_W'(flat);
  endfunction

  // The result register frees up when empty or when its transaction completes.
  assign out_free = !out_valid_r || out_ready;

  always_comb begin
    // A level code at or above LEVELS is a no-op enqueue.
    lvl_ok   = 32'(lvl_r) < 32'(LEVELS);
    lvl_idx  = LVL_W'(lvl_r);
    enq_busy = lvl_ok && busy_r[lvl_idx];
    enq_tail = lvl_ok ? tail_r[lvl_idx] : '0;
    // Linear queue: once the tail sits in the last slot the level is full
    // until it drains completely.
    enq_full = enq_busy && (enq_tail == LAST_IDX);
    enq_slot = enq_busy ? enq_tail + IDX_W'(1) : '0;

    ram_we    = (state_r == S_ENQ) && out_free && lvl_ok && !enq_full;
    ram_waddr = slot_addr(lvl_idx, enq_slot);
    // Stored words are the sign-extended (or truncated) input value.
    ram_wdata = DATA_WIDTH'(val_r);

    // The scan compares one level per cycle, from the most urgent down.
    scan_hit  = busy_r[scan_r];
    scan_head = head_r[scan_r];
    scan_tail = tail_r[scan_r];
    ram_re    = (state_r == S_SCAN) && scan_hit;
    ram_raddr = slot_addr(scan_r, scan_head);

    // A result is latched this cycle: enqueue outcome, read data or underflow.
    out_load = out_free && ((state_r == S_ENQ) || (state_r == S_READ) ||
               ((state_r == S_SCAN) && !scan_hit && (scan_r == LAST_LVL)));
  end

  mpq_slot_ram #(
    .WORDS  (WORDS),
    .ADDR_W (ADDR_W),
    .DATA_W (DATA_WIDTH)
  ) u_slot_ram (
    .clk     (clk),
    .wr_en   (ram_we),
    .wr_addr (ram_waddr),
    .wr_data (ram_wdata),
    .rd_en   (ram_re),
    .rd_addr (ram_raddr),
    .rd_data (ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      busy_r      <= '0;
      out_valid_r <= 1'b0;
      scan_r      <= '0;
      for (int i = 0; i < LEVELS; i++) begin
        head_r[i] <= '0;
        tail_r[i] <= '0;
      end
    end else begin
      // The result register either takes a new result or empties after its
      // transaction completes.
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end

      case (state_r)
        S_IDLE: begin
          // A new transaction may be taken while the previous result waits.
          if (in_valid) begin
            lvl_r   <= in_level;
            val_r   <= in_value;
            scan_r  <= '0;
            state_r <= (in_operation == OP_ENQ) ? S_ENQ : S_SCAN;
          end
        end

        S_ENQ: begin
          if (out_free) begin
            if (lvl_ok && !enq_full) begin
              busy_r[lvl_idx] <= 1'b1;
              tail_r[lvl_idx] <= enq_slot;
              if (!enq_busy) begin
                head_r[lvl_idx] <= '0;
              end
            end
            out_value_r  <= '0;
            out_status_r <= enq_full ? ST_OVERFLOW : ST_OK;
            state_r      <= S_IDLE;
          end
        end

        S_SCAN: begin
          if (scan_hit) begin
            // The read of the head slot is issued now; pointers move at once.
            if (scan_head == scan_tail) begin
              busy_r[scan_r] <= 1'b0;
              head_r[scan_r] <= '0;
              tail_r[scan_r] <= '0;
            end else begin
              head_r[scan_r] <= scan_head + IDX_W'(1);
            end
            state_r <= S_READ;
          end else if (scan_r == LAST_LVL) begin
            if (out_free) begin
              out_value_r  <= '0;
              out_status_r <= ST_UNDERFLOW;
              state_r      <= S_IDLE;
            end
          end else begin
            scan_r <= scan_r + LVL_W'(1);
          end
        end

        S_READ: begin
          // The memory holds its read data until the result register frees.
          if (out_free) begin
            out_value_r  <= VALUE_W'(ram_rdata);
            out_status_r <= ST_OK;
            state_r      <= S_IDLE;
          end
        end

        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

  assign in_ready         = (state_r == S_IDLE);
  assign out_valid        = out_valid_r;
  assign out_result_value = out_value_r;
  assign out_status       = out_status_r;

endmodule

// ===== design/mpq_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mpq_props: port-level checks of the multilevel priority queue
// Tracks the operation behind the result on display and checks results.
// ----------------------------------------------------------------------------
module mpq_props (
  input logic                               clk,
  input logic                               rst_n,
  input logic                               in_valid,
  input logic                               in_ready,
  input mpq_pkg::op_t                       in_operation,
  input logic                               out_valid,
  input logic                               out_ready,
  input logic signed [mpq_pkg::VALUE_W-1:0] out_result_value,
  input mpq_pkg::status_t                   out_status
);

  import mpq_pkg::*;

  logic       in_acc;
  logic       out_acc;
  logic [1:0] op_cnt_r;
  op_t        head_op_r;
  op_t        next_op_r;
  op_t        head_op_nxt;
  op_t        next_op_nxt;

  assign in_acc  = in_valid && in_ready;
  assign out_acc = out_valid && out_ready;

  // Accepted operations in order; the oldest one owns the result on display.
  always_comb begin
    head_op_nxt = head_op_r;
    next_op_nxt = next_op_r;
    if (out_acc) begin
      head_op_nxt = next_op_r;
    end
    if (in_acc) begin
      if (op_cnt_r == 2'd0 || (op_cnt_r == 2'd1 && out_acc)) begin
        head_op_nxt = in_operation;
      end else begin
        next_op_nxt = in_operation;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      op_cnt_r <= '0;
    end else begin
      op_cnt_r  <= op_cnt_r + {1'b0, in_acc} - {1'b0, out_acc};
      head_op_r <= head_op_nxt;
      next_op_r <= next_op_nxt;
    end
  end

  // A stalled result holds its payload.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_result_value) && $stable(out_status))
    else $error("result changed while stalled");

  // Only one transaction is processed at a time: input is closed right after acceptance.
  a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("input accepted while busy");

  // An enqueue result carries a zero value and never reports underflow.
  a_enq_result: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && head_op_r == OP_ENQ |->
      out_result_value == '0 && out_status != ST_UNDERFLOW)
    else $error("bad enqueue result");

  // A dequeue never overflows, and an underflow returns zero.
  a_deq_result: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && head_op_r == OP_DEQ |->
      out_status != ST_OVERFLOW &&
      (out_status != ST_UNDERFLOW || out_result_value == '0))
    else $error("bad dequeue result");

endmodule

bind multilevel_priority_queue mpq_props u_mpq_props (
  .clk              (clk),
  .rst_n            (rst_n),
  .in_valid         (in_valid),
  .in_ready         (in_ready),
  .in_operation     (in_operation),
  .out_valid        (out_valid),
  .out_ready        (out_ready),
  .out_result_value (out_result_value),
  .out_status       (out_status)
);
